// ===== src/tlvd_pkg.sv =====
package tlvd_pkg;

    // Width of the byte and record counters
    localparam int COUNT_BITS = 16;
    localparam int FIELD_BITS = 16;
    localparam int WIDE_BITS  = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS + 1;

    typedef logic [COUNT_BITS-1:0] cnt_t;
    typedef logic [FIELD_BITS-1:0] field_t;

    localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

    // Byte role codes
    localparam logic [1:0] ROLE_TAG    = 2'd0;
    localparam logic [1:0] ROLE_LENGTH = 2'd1;
    localparam logic [1:0] ROLE_VALUE  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tlvd_in_t;

    typedef struct packed {
        logic [1:0] byte_role;
        logic [7:0] record_tag;
        logic [7:0] record_length;
        logic [7:0] value_offset;
        logic [7:0] echoed_byte;
        logic       record_complete;
        logic       stream_end;
        logic       truncated;
        field_t     consumed_count;
        field_t     record_count;
    } tlvd_out_t;

    // Increment, holding at the top of the range
    function automatic cnt_t cnt_sat_inc(input cnt_t v);
        cnt_t r;
        if (v == CNT_MAX) begin
            r = CNT_MAX;
        end
        else begin
            r = v + cnt_t'(1);
        end
        return r;
    endfunction

    // Add two, holding at the top of the range
    function automatic cnt_t cnt_sat_add2(input cnt_t v);
        logic [COUNT_BITS:0] s;
        s = {1'b0, v} + (COUNT_BITS+1)'(2);
        if (s[COUNT_BITS]) begin
            return CNT_MAX;
        end
        return s[COUNT_BITS-1:0];
    endfunction

    // Clamp a counter to the 16-bit result field
    function automatic field_t cnt_to_field(input cnt_t v);
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(v);
        if (w > WIDE_BITS'({FIELD_BITS{1'b1}})) begin
            return {FIELD_BITS{1'b1}};
        end
        return w[FIELD_BITS-1:0];
    endfunction

endpackage

// ===== src/tlv_stream_deframer_core.sv =====
// TLV stream deframer: labels every byte as tag, length or value of a record.
// Each result appears in the cycle after its input transfer (the result register).
// Throughput: one byte per cycle; the input stalls only while a result is held
// in the result register under output stall.
// Reset (rst_n low, asynchronous): expect a tag byte, all counters zero,
// no result pending. The same stream state is cleared after each last byte.
module tlv_stream_deframer_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tlvd_pkg::tlvd_in_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tlvd_pkg::tlvd_out_t out_data
);
    import tlvd_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG = 2'd0,
        PH_LEN = 2'd1,
        PH_VAL = 2'd2
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_tag_reg, held_tag_next;
    logic [7:0] held_length_reg, held_length_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] offset_reg, offset_next;
    cnt_t       byte_counter_reg, byte_counter_next;
    cnt_t       record_start_reg, record_start_next;
    cnt_t       records_done_reg, records_done_next;

    tlvd_out_t  res_reg, res_next;
    logic       res_valid_reg;
    logic       accept;
    logic       done;
    logic [1:0] role;
    logic [7:0] len_out;
    logic [7:0] off_out;

    // A new byte may enter whenever the result register is free or being drained
    assign in_stall  = res_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    // Next stream state and result for the byte at the input
    always_comb
    begin
        phase_next        = phase_reg;
        held_tag_next     = held_tag_reg;
        held_length_next  = held_length_reg;
        bytes_left_next   = bytes_left_reg;
        offset_next       = offset_reg;
        record_start_next = record_start_reg;
        role              = ROLE_TAG;
        len_out           = 8'd0;
        off_out           = 8'd0;
        done              = 1'b0;

        unique case (phase_reg)
            PH_LEN:
            begin
                role             = ROLE_LENGTH;
                held_length_next = in_data.data_byte;
                bytes_left_next  = in_data.data_byte;
                offset_next      = 8'd0;
                len_out          = in_data.data_byte;
                if (in_data.data_byte == 8'd0) begin
                    // Empty value: the record ends on its length byte
                    done       = 1'b1;
                    phase_next = PH_TAG;
                end
                else begin
                    phase_next = PH_VAL;
                end
            end
            PH_VAL:
            begin
                role            = ROLE_VALUE;
                len_out         = held_length_reg;
                off_out         = offset_reg;
                offset_next     = offset_reg + 8'd1;
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_next == 8'd0) begin
                    done       = 1'b1;
                    phase_next = PH_TAG;
                end
            end
            default:
            begin
                // Tag byte; the unused phase code is taken as a tag phase too
                role              = ROLE_TAG;
                held_tag_next     = in_data.data_byte;
                record_start_next = byte_counter_reg;
                phase_next        = PH_LEN;
            end
        endcase

        byte_counter_next = cnt_sat_inc(byte_counter_reg);
        records_done_next = done ? cnt_sat_inc(records_done_reg) : records_done_reg;

        res_next.byte_role       = role;
        res_next.record_tag      = held_tag_next;
        res_next.record_length   = len_out;
        res_next.value_offset    = off_out;
        res_next.echoed_byte     = in_data.data_byte;
        res_next.record_complete = done;
        res_next.stream_end      = in_data.last_byte;
        res_next.record_count    = cnt_to_field(records_done_next);
        res_next.truncated       = 1'b0;
        res_next.consumed_count  = '0;

        if (in_data.last_byte) begin
            res_next.truncated = (phase_next != PH_TAG);
            // A cut value counts only up to its length byte
            if (phase_next == PH_VAL) begin
                res_next.consumed_count = cnt_to_field(cnt_sat_add2(record_start_next));
            end
            else begin
                res_next.consumed_count = cnt_to_field(byte_counter_next);
            end
            // Drop all stream state ready for the next stream
            phase_next        = PH_TAG;
            held_tag_next     = 8'd0;
            held_length_next  = 8'd0;
            bytes_left_next   = 8'd0;
            offset_next       = 8'd0;
            byte_counter_next = '0;
            record_start_next = '0;
            records_done_next = '0;
        end
    end

    // Advance state and load the result register on every input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg        <= PH_TAG;
            held_tag_reg     <= 8'd0;
            held_length_reg  <= 8'd0;
            bytes_left_reg   <= 8'd0;
            offset_reg       <= 8'd0;
            byte_counter_reg <= '0;
            record_start_reg <= '0;
            records_done_reg <= '0;
            res_valid_reg    <= 1'b0;
            res_reg          <= '0;
        end
        else begin
            if (accept) begin
                phase_reg        <= phase_next;
                held_tag_reg     <= held_tag_next;
                held_length_reg  <= held_length_next;
                bytes_left_reg   <= bytes_left_next;
                offset_reg       <= offset_next;
                byte_counter_reg <= byte_counter_next;
                record_start_reg <= record_start_next;
                records_done_reg <= records_done_next;
                res_reg          <= res_next;
                res_valid_reg    <= 1'b1;
            end
            else if (!out_stall) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // A value phase always has bytes outstanding
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_VAL |-> bytes_left_reg != 8'd0)
        else $error("value phase with no bytes left");

    // The last byte leaves a cleared stream behind
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.last_byte |=> phase_reg == PH_TAG && byte_counter_reg == '0
            && records_done_reg == '0)
        else $error("stream state not cleared after last byte");

    // A tag byte never completes a record and carries no length or offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_role == ROLE_TAG |-> !out_data.record_complete
            && out_data.value_offset == 8'd0 && out_data.record_length == 8'd0)
        else $error("tag byte result carries record fields");

    // Truncation and consumed count appear only at stream end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.stream_end |-> !out_data.truncated
            && out_data.consumed_count == '0)
        else $error("end-of-stream fields set mid-stream");

endmodule
